@@ sv/assert_macros.svh @@
// assertion helpers, clocked on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// condition holds at every edge
`define POTT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define POTT_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`else

`define POTT_ASSERT(lbl, cond, msg)
`define POTT_ASSERT_IMPL(lbl, pre, post, msg)

`endif

`endif

@@ sv/pott_pkg.sv @@
`default_nettype none

package pott_pkg;

  localparam int ID_W            = 31;
  localparam int PRIO_W          = 3;
  localparam int ST_W            = 2;
  localparam int CODE_W          = 3;
  localparam int ACT_W           = 3;
  localparam int IN_DATA_W       = 40;
  localparam int OUT_DATA_W      = 40;
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int N_W             = $clog2(MAX_RESULTS + 1);

  localparam logic [PRIO_W-1:0] PRIO_MIN   = 3'd1;
  localparam logic [PRIO_W-1:0] PRIO_MAX   = 3'd5;
  localparam logic [ST_W-1:0]   STATUS_MAX = 2'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_UPDATE = 3'd2,
    ACT_SEARCH = 3'd3,
    ACT_LIST   = 3'd4
  } action_t;

  typedef enum logic [CODE_W-1:0] {
    RC_OK       = 3'd0,
    RC_DUP      = 3'd1,
    RC_NOTFOUND = 3'd2,
    RC_FULL     = 3'd3,
    RC_EMPTY    = 3'd4
  } rcode_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [ST_W-1:0]   status;
  } entry_t;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_PREV,
    RD_NEXT
  } rsel_t;

  typedef enum logic [1:0] {
    WR_SHIFT,
    WR_NEW,
    WR_UPD
  } wsel_t;

  typedef enum logic [2:0] {
    PUSH_ERR,
    PUSH_NEW,
    PUSH_HIT,
    PUSH_UPD,
    PUSH_PEND
  } psel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_REPLY,
    S_UP_RD,
    S_UP_WR,
    S_INSERT,
    S_DOWN_RD,
    S_DOWN_WR,
    S_EMIT_RD,
    S_EMIT_CHK
  } state_t;

  typedef struct packed {
    logic    load;
    logic    idx_clr;
    logic    idx_inc;
    logic    idx_dec;
    logic    idx_to_count;
    logic    idx_to_hit;
    logic    rd_en;
    rsel_t   rd_sel;
    logic    chk;
    logic    wr_en;
    wsel_t   wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit_clr;
    logic    pend_load;
    logic    push;
    psel_t   push_sel;
    rcode_t  push_code;
    logic    push_last;
  } ctrl_t;

  typedef struct packed {
    action_t act;
    logic    idx_eq_count;
    logic    idx_eq_pos;
    logic    idx_last;
    logic    count_zero;
    logic    count_full;
    logic    match_id;
    logic    emit_match;
    logic    hit;
    logic    pend_valid;
    logic    n_max;
    logic    out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ sv/pott_ctrl.sv @@
`default_nettype none

module pott_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              s_valid,
  output logic             in_ready,
  input  pott_pkg::stat_t  stat,
  output pott_pkg::ctrl_t  ctrl
);

  pott_pkg::state_t state;
  pott_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pott_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pott_pkg::S_IDLE: begin
        if (s_valid) state_next = pott_pkg::S_START;
      end
      pott_pkg::S_START: begin
        unique case (stat.act) inside
          pott_pkg::ACT_ADD, pott_pkg::ACT_DELETE, pott_pkg::ACT_UPDATE:
            state_next = pott_pkg::S_SCAN_RD;
          pott_pkg::ACT_SEARCH, pott_pkg::ACT_LIST:
            state_next = pott_pkg::S_DECIDE;
          default:
            state_next = pott_pkg::S_IDLE;
        endcase
      end
      pott_pkg::S_SCAN_RD: begin
        state_next = stat.idx_eq_count ? pott_pkg::S_DECIDE : pott_pkg::S_SCAN_CHK;
      end
      pott_pkg::S_SCAN_CHK: begin
        state_next = stat.match_id ? pott_pkg::S_DECIDE : pott_pkg::S_SCAN_RD;
      end
      pott_pkg::S_DECIDE: begin
        unique case (stat.act) inside
          pott_pkg::ACT_ADD: begin
            if (stat.hit || stat.count_full) state_next = pott_pkg::S_REPLY;
            else state_next = pott_pkg::S_UP_RD;
          end
          pott_pkg::ACT_DELETE, pott_pkg::ACT_UPDATE:
            state_next = pott_pkg::S_REPLY;
          pott_pkg::ACT_SEARCH, pott_pkg::ACT_LIST: begin
            if (stat.count_zero) state_next = pott_pkg::S_REPLY;
            else state_next = pott_pkg::S_EMIT_RD;
          end
          default:
            state_next = pott_pkg::S_IDLE;
        endcase
      end
      pott_pkg::S_REPLY: begin
        if (stat.out_free) begin
          if (stat.act == pott_pkg::ACT_DELETE && !stat.count_zero && stat.hit) begin
            state_next = pott_pkg::S_DOWN_RD;
          end else begin
            state_next = pott_pkg::S_IDLE;
          end
        end
      end
      pott_pkg::S_UP_RD: begin
        state_next = stat.idx_eq_pos ? pott_pkg::S_INSERT : pott_pkg::S_UP_WR;
      end
      pott_pkg::S_UP_WR: begin
        state_next = pott_pkg::S_UP_RD;
      end
      pott_pkg::S_INSERT: begin
        if (stat.out_free) state_next = pott_pkg::S_IDLE;
      end
      pott_pkg::S_DOWN_RD: begin
        state_next = stat.idx_last ? pott_pkg::S_IDLE : pott_pkg::S_DOWN_WR;
      end
      pott_pkg::S_DOWN_WR: begin
        state_next = pott_pkg::S_DOWN_RD;
      end
      pott_pkg::S_EMIT_RD: begin
        if (stat.idx_eq_count || stat.n_max) state_next = pott_pkg::S_REPLY;
        else state_next = pott_pkg::S_EMIT_CHK;
      end
      pott_pkg::S_EMIT_CHK: begin
        if (!stat.emit_match) begin
          state_next = pott_pkg::S_EMIT_RD;
        end else if (!(stat.pend_valid && !stat.out_free)) begin
          state_next = pott_pkg::S_EMIT_RD;
        end
      end
      default: state_next = pott_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl           = '0;
    ctrl.rd_sel    = pott_pkg::RD_IDX;
    ctrl.wr_sel    = pott_pkg::WR_SHIFT;
    ctrl.push_sel  = pott_pkg::PUSH_ERR;
    ctrl.push_code = pott_pkg::RC_OK;
    ctrl.push_last = 1'b1;
    in_ready       = 1'b0;
    unique case (state)
      pott_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = s_valid;
      end
      pott_pkg::S_START: begin
      end
      pott_pkg::S_SCAN_RD: begin
        ctrl.rd_en = !stat.idx_eq_count;
      end
      pott_pkg::S_SCAN_CHK: begin
        ctrl.chk     = 1'b1;
        ctrl.idx_inc = 1'b1;
      end
      pott_pkg::S_DECIDE: begin
        unique case (stat.act) inside
          pott_pkg::ACT_ADD: begin
            ctrl.idx_to_count = !stat.hit && !stat.count_full;
          end
          pott_pkg::ACT_UPDATE: begin
            ctrl.wr_en  = !stat.count_zero && stat.hit;
            ctrl.wr_sel = pott_pkg::WR_UPD;
          end
          pott_pkg::ACT_SEARCH, pott_pkg::ACT_LIST: begin
            ctrl.idx_clr  = !stat.count_zero;
            ctrl.emit_clr = !stat.count_zero;
          end
          default: begin
          end
        endcase
      end
      pott_pkg::S_REPLY: begin
        if (stat.out_free) begin
          ctrl.push = 1'b1;
          unique case (stat.act) inside
            pott_pkg::ACT_ADD: begin
              ctrl.push_code = stat.hit ? pott_pkg::RC_DUP : pott_pkg::RC_FULL;
            end
            pott_pkg::ACT_DELETE, pott_pkg::ACT_UPDATE: begin
              if (stat.count_zero) begin
                ctrl.push_code = pott_pkg::RC_EMPTY;
              end else if (!stat.hit) begin
                ctrl.push_code = pott_pkg::RC_NOTFOUND;
              end else if (stat.act == pott_pkg::ACT_DELETE) begin
                ctrl.push_sel   = pott_pkg::PUSH_HIT;
                ctrl.idx_to_hit = 1'b1;
              end else begin
                ctrl.push_sel = pott_pkg::PUSH_UPD;
              end
            end
            pott_pkg::ACT_SEARCH, pott_pkg::ACT_LIST: begin
              if (stat.count_zero) begin
                ctrl.push_code = pott_pkg::RC_EMPTY;
              end else if (stat.pend_valid) begin
                ctrl.push_sel = pott_pkg::PUSH_PEND;
              end else begin
                ctrl.push_code = pott_pkg::RC_NOTFOUND;
              end
            end
            default: ctrl.push = 1'b0;
          endcase
        end
      end
      pott_pkg::S_UP_RD: begin
        ctrl.rd_en  = !stat.idx_eq_pos;
        ctrl.rd_sel = pott_pkg::RD_PREV;
      end
      pott_pkg::S_UP_WR: begin
        ctrl.wr_en   = 1'b1;
        ctrl.idx_dec = 1'b1;
      end
      pott_pkg::S_INSERT: begin
        if (stat.out_free) begin
          ctrl.wr_en    = 1'b1;
          ctrl.wr_sel   = pott_pkg::WR_NEW;
          ctrl.cnt_inc  = 1'b1;
          ctrl.push     = 1'b1;
          ctrl.push_sel = pott_pkg::PUSH_NEW;
        end
      end
      pott_pkg::S_DOWN_RD: begin
        ctrl.cnt_dec = stat.idx_last;
        ctrl.rd_en   = !stat.idx_last;
        ctrl.rd_sel  = pott_pkg::RD_NEXT;
      end
      pott_pkg::S_DOWN_WR: begin
        ctrl.wr_en   = 1'b1;
        ctrl.idx_inc = 1'b1;
      end
      pott_pkg::S_EMIT_RD: begin
        ctrl.rd_en = !(stat.idx_eq_count || stat.n_max);
      end
      pott_pkg::S_EMIT_CHK: begin
        if (!stat.emit_match) begin
          ctrl.idx_inc = 1'b1;
        end else if (!(stat.pend_valid && !stat.out_free)) begin
          // the held match, if any, goes out now, it is not the last one
          ctrl.push      = stat.pend_valid;
          ctrl.push_sel  = pott_pkg::PUSH_PEND;
          ctrl.push_last = 1'b0;
          ctrl.pend_load = 1'b1;
          ctrl.idx_inc   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/pott_dp.sv @@
`default_nettype none

module pott_dp #(
  parameter int TABLE_DEPTH = pott_pkg::TABLE_DEPTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire [pott_pkg::ACT_W-1:0]    in_action,
  input  wire [pott_pkg::ID_W-1:0]     in_id,
  input  wire [pott_pkg::PRIO_W-1:0]   in_prio,
  input  wire [pott_pkg::ST_W-1:0]     in_status,
  input  wire                          out_ready,
  input  pott_pkg::ctrl_t              ctrl,
  output pott_pkg::stat_t              stat,
  output logic                         out_valid,
  output pott_pkg::entry_t             out_entry,
  output pott_pkg::rcode_t             out_code,
  output logic                         out_last
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IW = $clog2(TABLE_DEPTH + 1);

  pott_pkg::entry_t mem [TABLE_DEPTH];

  pott_pkg::action_t              cmd_act;
  logic [pott_pkg::ID_W-1:0]      cmd_id;
  logic [pott_pkg::PRIO_W-1:0]    cmd_prio;
  logic [pott_pkg::ST_W-1:0]      cmd_status;
  logic [IW-1:0]                  idx;
  logic [IW-1:0]                  count;
  logic [IW-1:0]                  pos;
  logic                           pos_found;
  logic                           hit;
  logic [IW-1:0]                  hit_idx;
  pott_pkg::entry_t               hit_entry;
  pott_pkg::entry_t               rdata;
  pott_pkg::entry_t               pend;
  logic                           pend_valid;
  logic [pott_pkg::N_W-1:0]       n;

  logic [pott_pkg::PRIO_W-1:0]    add_prio;
  logic [IW-1:0]                  pos_eff;
  logic [IW-1:0]                  raddr_full;
  logic [AW-1:0]                  raddr;
  logic [IW-1:0]                  waddr_full;
  logic [AW-1:0]                  waddr;
  pott_pkg::entry_t               wdata;
  pott_pkg::entry_t               new_entry;
  pott_pkg::entry_t               upd_entry;
  pott_pkg::entry_t               push_entry;
  pott_pkg::rcode_t               push_code;

  always_comb begin
    if (cmd_prio < pott_pkg::PRIO_MIN) add_prio = pott_pkg::PRIO_MIN;
    else if (cmd_prio > pott_pkg::PRIO_MAX) add_prio = pott_pkg::PRIO_MAX;
    else add_prio = cmd_prio;
  end

  assign pos_eff   = pos_found ? pos : count;
  assign new_entry = '{id: cmd_id, prio: add_prio, status: cmd_status};
  assign upd_entry = '{id: hit_entry.id, prio: hit_entry.prio, status: cmd_status};

  // status towards the controller
  always_comb begin
    stat.act          = cmd_act;
    stat.idx_eq_count = (idx == count);
    stat.idx_eq_pos   = (idx == pos_eff);
    stat.idx_last     = ({1'b0, idx} + {{IW{1'b0}}, 1'b1}) >= {1'b0, count};
    stat.count_zero   = (count == '0);
    stat.count_full   = (count == IW'(TABLE_DEPTH));
    stat.match_id     = (rdata.id == cmd_id);
    stat.emit_match   = (cmd_act == pott_pkg::ACT_LIST) || (rdata.prio == cmd_prio);
    stat.hit          = hit;
    stat.pend_valid   = pend_valid;
    stat.n_max        = (n == pott_pkg::N_W'(pott_pkg::MAX_RESULTS));
    stat.out_free     = !out_valid || out_ready;
  end

  always_comb begin
    case (ctrl.rd_sel)
      pott_pkg::RD_PREV: raddr_full = idx - {{(IW-1){1'b0}}, 1'b1};
      pott_pkg::RD_NEXT: raddr_full = idx + {{(IW-1){1'b0}}, 1'b1};
      default:           raddr_full = idx;
    endcase
    raddr = raddr_full[AW-1:0];
  end

  always_comb begin
    case (ctrl.wr_sel)
      pott_pkg::WR_NEW: begin
        waddr_full = pos_eff;
        wdata      = new_entry;
      end
      pott_pkg::WR_UPD: begin
        waddr_full = hit_idx;
        wdata      = upd_entry;
      end
      default: begin
        waddr_full = idx;
        wdata      = rdata;
      end
    endcase
    waddr = waddr_full[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) mem[waddr] <= wdata;
    if (ctrl.rd_en) rdata <= mem[raddr];
  end

  // command capture
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_act    <= pott_pkg::action_t'(in_action);
      cmd_id     <= in_id;
      cmd_prio   <= in_prio;
      cmd_status <= (in_status > pott_pkg::STATUS_MAX) ? pott_pkg::STATUS_MAX : in_status;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load || ctrl.idx_clr) idx <= '0;
    else if (ctrl.idx_to_count) idx <= count;
    else if (ctrl.idx_to_hit) idx <= hit_idx;
    else if (ctrl.idx_inc) idx <= idx + {{(IW-1){1'b0}}, 1'b1};
    else if (ctrl.idx_dec) idx <= idx - {{(IW-1){1'b0}}, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.cnt_inc) begin
      count <= count + {{(IW-1){1'b0}}, 1'b1};
    end else if (ctrl.cnt_dec) begin
      count <= count - {{(IW-1){1'b0}}, 1'b1};
    end
  end

  // id lookup and insert point, first slot of lower priority
  always_ff @(posedge clk) begin
    if (rst || ctrl.load) begin
      hit       <= 1'b0;
      pos_found <= 1'b0;
    end else if (ctrl.chk) begin
      if (stat.match_id) begin
        hit <= 1'b1;
      end
      if (!pos_found && rdata.prio < add_prio) begin
        pos_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.chk) begin
      if (stat.match_id) begin
        hit_idx   <= idx;
        hit_entry <= rdata;
      end
      if (!pos_found && rdata.prio < add_prio) begin
        pos <= idx;
      end
    end
  end

  // one match is held back so the final one can carry last
  always_ff @(posedge clk) begin
    if (rst || ctrl.emit_clr) begin
      pend_valid <= 1'b0;
    end else if (ctrl.pend_load) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_clr) begin
      n <= '0;
    end else if (ctrl.pend_load) begin
      n <= n + {{(pott_pkg::N_W-1){1'b0}}, 1'b1};
    end
    if (ctrl.pend_load) pend <= rdata;
  end

  always_comb begin
    push_code  = pott_pkg::RC_OK;
    case (ctrl.push_sel)
      pott_pkg::PUSH_NEW:  push_entry = new_entry;
      pott_pkg::PUSH_HIT:  push_entry = hit_entry;
      pott_pkg::PUSH_UPD:  push_entry = upd_entry;
      pott_pkg::PUSH_PEND: push_entry = pend;
      default: begin
        push_entry = '0;
        push_code  = ctrl.push_code;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      out_entry <= push_entry;
      out_code  <= push_code;
      out_last  <= ctrl.push_last;
    end
  end

endmodule

`default_nettype wire

@@ sv/priority_ordered_task_table_top.sv @@
// add: scans the entries for an id match, then shifts each entry from the insert point on by one slot
// delete and update: scan the entries up to the hit, delete then closes up the entries after it
// search and list: walk the entries, results leave through a one-deep output register
// throughput: one item at a time, the next is taken once the controller is back in idle
// reset: rst is synchronous, empties the table and the output register
// table contents are not cleared and are never read before written
`default_nettype none
`include "assert_macros.svh"

module priority_ordered_task_table_top #(
  parameter int TABLE_DEPTH = pott_pkg::TABLE_DEPTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  // entry_id [30:0], entry_priority [33:31], new_status [35:34], zero fill
  input  wire [pott_pkg::IN_DATA_W-1:0]      s_tdata,
  // action
  input  wire [pott_pkg::ACT_W-1:0]          s_tuser,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // out_id [30:0], out_priority [33:31], out_status [35:34], zero fill
  output logic [pott_pkg::OUT_DATA_W-1:0]    m_tdata,
  // result_code
  output logic [pott_pkg::CODE_W-1:0]        m_tuser,
  output logic                               m_tlast
);

  pott_pkg::ctrl_t   dp_ctrl;
  pott_pkg::stat_t   dp_stat;
  pott_pkg::entry_t  out_entry;
  pott_pkg::rcode_t  out_code;

  pott_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_tvalid),
    .in_ready (s_tready),
    .stat     (dp_stat),
    .ctrl     (dp_ctrl)
  );

  pott_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_action (s_tuser),
    .in_id     (s_tdata[30:0]),
    .in_prio   (s_tdata[33:31]),
    .in_status (s_tdata[35:34]),
    .out_ready (m_tready),
    .ctrl      (dp_ctrl),
    .stat      (dp_stat),
    .out_valid (m_tvalid),
    .out_entry (out_entry),
    .out_code  (out_code),
    .out_last  (m_tlast)
  );

  assign m_tdata = {4'b0000, out_entry.status, out_entry.prio, out_entry.id};
  assign m_tuser = out_code;

  `POTT_ASSERT(a_no_overwrite, !(dp_ctrl.push && m_tvalid && !m_tready), "result overwritten before taken")
  `POTT_ASSERT_IMPL(a_insert_room, dp_ctrl.cnt_inc, !dp_stat.count_full, "insert into a full table")
  `POTT_ASSERT_IMPL(a_delete_some, dp_ctrl.cnt_dec, !dp_stat.count_zero, "delete from an empty table")
  `POTT_ASSERT(a_error_is_last, !(m_tvalid && m_tuser != pott_pkg::RC_OK && !m_tlast), "error result without last")

endmodule

`default_nettype wire
